/* rtl/cgbq_pkg.sv */
// Shared constants, types and ring helpers for the credit gated batching queue.
package cgbq_pkg;

	localparam int QUEUE_SLOTS = 64;
	localparam int BATCH_MAX   = 8;

	localparam int IDX_W    = $clog2(QUEUE_SLOTS);
	localparam int WORD_W   = 64;
	localparam int SLOT_W   = 16;
	localparam int QUEUED_W = 6;
	localparam int FILL_W   = 4;
	localparam int OP_W     = 3;
	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 104;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_CAP    = 3'd1,
		OP_STATUS = 3'd2,
		OP_FLUSH  = 3'd3,
		OP_SEND   = 3'd4
	} op_t;

	typedef struct packed {
		logic push;
		logic set_cap;
		logic set_status;
		logic flush;
		logic pop;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic can_send;
		logic out_free;
		logic pop_ends;
	} sts_t;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
		ring_next = (idx == IDX_W'(QUEUE_SLOTS - 1)) ? '0 : IDX_W'(idx + 1'b1);
	endfunction

	function automatic logic [QUEUED_W-1:0] ring_count(input logic [IDX_W-1:0] wi,
	                                                   input logic [IDX_W-1:0] ri);
		logic [IDX_W:0] t;
		if (wi >= ri) begin
			t = {1'b0, wi} - {1'b0, ri};
		end else begin
			t = {1'b0, wi} + (IDX_W+1)'(QUEUE_SLOTS) - {1'b0, ri};
		end
		ring_count = QUEUED_W'(t);
	endfunction

endpackage

/* rtl/cgbq_dp.sv */
// Datapath: segment ring memory, indices, credits, counters and output register.
module cgbq_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cgbq_pkg::cmd_t                    cmd,
	input  logic [cgbq_pkg::WORD_W-1:0]       segment_word,
	input  logic [cgbq_pkg::SLOT_W-1:0]       available_slots,
	input  logic [cgbq_pkg::SLOT_W-1:0]       total_slots,
	input  logic                              out_ready,
	output cgbq_pkg::sts_t                    sts,
	output logic                              out_valid,
	output logic [cgbq_pkg::OUT_TDATA_W-1:0]  out_tdata,
	output logic                              out_tuser,
	output logic                              out_last
);
	import cgbq_pkg::*;

	logic [WORD_W-1:0]   mem [QUEUE_SLOTS];
	logic [WORD_W-1:0]   rdata_q;
	logic [IDX_W-1:0]    wi_q, ri_q, wi_d, ri_d, ri_nxt, wi_nxt, rd_addr;
	logic [SLOT_W-1:0]   credits_q, credits_d, drop_q, drop_d;
	logic [FILL_W-1:0]   fill_q, fill_d, fill_inc;
	logic [QUEUED_W-1:0] cnt, cnt_d;
	logic                mem_we, ends, closes;

	logic                out_valid_q;
	logic [WORD_W-1:0]   word_q;
	logic                closes_q, last_q, segv_q;
	logic [SLOT_W-1:0]   credits_out_q, drop_out_q;
	logic [QUEUED_W-1:0] cnt_out_q;

	always_comb begin
		cnt      = ring_count(wi_q, ri_q);
		ri_nxt   = ring_next(ri_q);
		wi_nxt   = ring_next(wi_q);
		fill_inc = fill_q + 1'b1;
		wi_d      = wi_q;
		ri_d      = ri_q;
		credits_d = credits_q;
		drop_d    = drop_q;
		fill_d    = fill_q;
		mem_we    = 1'b0;
		ends      = 1'b0;
		closes    = 1'b0;
		if (cmd.push) begin
			if (wi_nxt == ri_q) begin
				if (drop_q != '1) begin
					drop_d = drop_q + 1'b1;
				end
			end else begin
				mem_we = 1'b1;
				wi_d   = wi_nxt;
			end
		end
		if (cmd.set_cap) begin
			credits_d = total_slots;
		end
		if (cmd.set_status) begin
			credits_d = available_slots;
		end
		if (cmd.flush) begin
			wi_d   = '0;
			ri_d   = '0;
			fill_d = '0;
		end
		ends   = (ring_count(wi_q, ri_nxt) == '0) || (credits_q == SLOT_W'(1));
		closes = ends || (fill_inc >= FILL_W'(BATCH_MAX));
		if (cmd.pop) begin
			ri_d      = ri_nxt;
			credits_d = credits_q - 1'b1;
			fill_d    = closes ? '0 : fill_inc;
		end
		cnt_d   = ring_count(wi_d, ri_d);
		rd_addr = cmd.pop ? ri_nxt : ri_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wi_q] <= segment_word;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q        <= '0;
			ri_q        <= '0;
			credits_q   <= '0;
			drop_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			wi_q      <= wi_d;
			ri_q      <= ri_d;
			credits_q <= credits_d;
			drop_q    <= drop_d;
			fill_q    <= fill_d;
			if (cmd.pop || cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop || cmd.emit) begin
			segv_q        <= cmd.pop;
			word_q        <= cmd.pop ? rdata_q : '0;
			closes_q      <= cmd.pop & closes;
			last_q        <= cmd.pop ? ends : 1'b1;
			credits_out_q <= credits_d;
			cnt_out_q     <= cnt_d;
			drop_out_q    <= drop_d;
		end
	end

	assign sts.can_send = (cnt != '0) && (credits_q != '0);
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.pop_ends = ends;

	assign out_valid = out_valid_q;
	assign out_tuser = segv_q;
	assign out_last  = last_q;
	assign out_tdata = {1'b0, drop_out_q, cnt_out_q, credits_out_q, closes_q, word_q};

endmodule

/* rtl/cgbq_ctrl.sv */
// Controller: decodes input items and sequences the send drain.
module cgbq_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [cgbq_pkg::OP_W-1:0]  op,
	input  logic                       link_up,
	input  cgbq_pkg::sts_t             sts,
	output logic                       in_ready,
	output cgbq_pkg::cmd_t             cmd
);
	import cgbq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_FETCH = 3'b010,
		ST_POP   = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   accept, send_go;

	assign in_ready = (state_q == ST_IDLE) && sts.out_free;
	assign accept   = in_valid && in_ready;
	assign send_go  = (op == OP_SEND) && link_up && sts.can_send;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op_t'(op))
						OP_PUSH:   cmd.push       = 1'b1;
						OP_CAP:    cmd.set_cap    = 1'b1;
						OP_STATUS: cmd.set_status = 1'b1;
						OP_FLUSH:  cmd.flush      = 1'b1;
						default:   ;
					endcase
					if (send_go) begin
						state_d = ST_FETCH;
					end else begin
						cmd.emit = 1'b1;
					end
				end
			end
			ST_FETCH: begin
				state_d = ST_POP;
			end
			ST_POP: begin
				if (sts.out_free) begin
					cmd.pop = 1'b1;
					if (sts.pop_ends) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/credit_gated_batching_queue.sv */
// Top level of the credit gated batching queue.
//
// Input channel s_axis: one item per event; tuser holds the op (push, set
// capacity, status update, flush, send), tdata the segment word, available
// and total remote slots and the link flag.
// Output channel m_axis: results; tuser flags a sent segment, tlast marks the
// final result of an input item, tdata carries the segment, batch close,
// credits left, queue depth and saturating drop count.
// Push, capacity, status, flush and unknown ops give one status result, which
// is in the output register in the cycle after the item is accepted.
// A send with link up, credits and queued segments passes a fetch state that
// reads the ring memory, then pops one segment per cycle while the receiver
// takes them, from the pop state into the output register. No item is
// accepted during a drain.
// A send that cannot pop gives one status result.
// The output register holds one result; an item or a pop enters only when it
// is empty or its result is taken in the same cycle.
// When m_axis stalls, the drain and input acceptance hold.
// Reset clears indices, credits, counters and the output valid; the ring
// memory is not cleared.
module credit_gated_batching_queue (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// segment_word, available_slots, total_slots, link_up, zero pad
	input  logic [cgbq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// op
	input  logic [cgbq_pkg::OP_W-1:0]           s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// sent_word, closes_packet, credits_left, queued, dropped_total, zero pad
	output logic [cgbq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// segment_valid
	output logic                                m_axis_tuser,
	output logic                                m_axis_tlast
);
	import cgbq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	logic [WORD_W-1:0] seg_word;
	logic [SLOT_W-1:0] avail, total;
	logic              link;

	assign seg_word = s_axis_tdata[WORD_W-1:0];
	assign avail    = s_axis_tdata[WORD_W+SLOT_W-1:WORD_W];
	assign total    = s_axis_tdata[WORD_W+2*SLOT_W-1:WORD_W+SLOT_W];
	assign link     = s_axis_tdata[WORD_W+2*SLOT_W];

	cgbq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.op       (s_axis_tuser),
		.link_up  (link),
		.sts      (sts),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	cgbq_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.segment_word    (seg_word),
		.available_slots (avail),
		.total_slots     (total),
		.out_ready       (m_axis_tready),
		.sts             (sts),
		.out_valid       (m_axis_tvalid),
		.out_tdata       (m_axis_tdata),
		.out_tuser       (m_axis_tuser),
		.out_last        (m_axis_tlast)
	);

endmodule
